### src/mktr_pkg.sv
// Package for the multi-keyboard typematic repeat core.
// Holds command codes, register indexes and reset values, field widths, the per-key entry layout and state codes.
// No dependencies.
package mktr_pkg;

  // Command codes carried in the input item's tuser
  typedef enum logic [2:0] {
    CMD_KEY    = 3'd0,
    CMD_TICK   = 3'd1,
    CMD_QUERY  = 3'd2,
    CMD_ADD    = 3'd3,
    CMD_REMOVE = 3'd4,
    CMD_CLEAR  = 3'd5
  } cmd_t;

  // Configuration register indexes and reset values
  localparam logic [7:0]  CFG_INITIAL_DELAY     = 8'd0;
  localparam logic [7:0]  CFG_REPEAT_INTERVAL   = 8'd1;
  localparam logic [15:0] RESET_INITIAL_DELAY   = 16'd360;
  localparam logic [15:0] RESET_REPEAT_INTERVAL = 16'd80;

  // Field widths
  localparam int DEV_W     = 32;
  localparam int KEY_W     = 9;
  localparam int TICK_W    = 16;
  localparam int CD_W      = 17;
  localparam int DIV_STEPS = 16;
  localparam int DIV_CNT_W = 4;

  // One key's state as stored in the key memory
  typedef struct packed {
    logic                   level_now;
    logic                   level_last;
    logic                   press;
    logic                   rep_flag;
    logic signed [CD_W-1:0] countdown;
  } key_entry_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_MAP,
    ST_KEY_RD,
    ST_KEY_WR,
    ST_Q_RD,
    ST_Q_DATA,
    ST_TK_RD,
    ST_TK_CALC,
    ST_TK_NEG,
    ST_TK_DIV,
    ST_TK_FIN,
    ST_TK_WR,
    ST_RESP
  } state_t;

endpackage

### src/multi_keyboard_typematic_repeat_core.sv
// Multi-keyboard typematic repeat core: slot table, key state memory and sequencer.
// Depends on mktr_pkg.
//
// Usage: each input item on the s_* channel carries a command in s_tuser
// (key event, frame tick, query, device add, device remove, clear all) and its
// operands in s_tdata. Every input item yields exactly one result item on the
// m_* channel. Registers are to be written on the cfg_* channel while the core is idle;
// the core itself does not enforce this. One item is worked at a time; s_tready is
// high only while the sequencer idles. Per item, a query reads its key; a key
// event on a mapped device reads and writes its key; creating or removing a slot
// also clears its KEY_COUNT keys; clear all clears all N = SLOT_COUNT * KEY_COUNT
// keys; a frame tick visits every key through the one key memory port, and a key
// whose countdown wraps runs a 16-step remainder on the shared subtractor.
// The result register is separate from the sequencer: the next item is taken
// while a result waits, and the sequencer holds in its result state only if a
// new result is ready before the receiver took the old one.
// After reset the core clears all N keys of the key memory before it accepts
// its first item; configuration writes are taken throughout.
module multi_keyboard_typematic_repeat_core #(
  parameter int SLOT_COUNT = 4,
  parameter int KEY_COUNT  = 512
) (
  input  logic        clk,
  input  logic        rst,
  // Input items
  input  logic        s_tvalid,
  output logic        s_tready,
  // s_tdata: device_id[31:0], key_code[40:32], key_down[41], delta_ticks[57:42],
  //          query_slot[59:58], allow_repeat[60], zero[63:61]
  input  logic [63:0] s_tdata,
  // s_tuser: command[2:0]
  input  logic [2:0]  s_tuser,
  // Result items
  output logic        m_tvalid,
  input  logic        m_tready,
  // m_tdata: slot[1:0], key_is_down[2], key_edge[3], zero[7:4]
  output logic [7:0]  m_tdata,
  // m_tuser: slot_ok[0]
  output logic        m_tuser,
  // Configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int TOTAL = SLOT_COUNT * KEY_COUNT;
  localparam int AW    = $clog2(TOTAL);
  localparam int SW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // Sequencer and sweep state
  mktr_pkg::state_t state, state_next;
  mktr_pkg::state_t clr_then;
  logic [AW-1:0]    sweep_addr;
  logic [AW-1:0]    sweep_end;

  // Configuration
  logic [15:0] cfg_init;
  logic [15:0] cfg_iv;
  logic [15:0] iv;

  // Slot table
  logic [SLOT_COUNT-1:0]           slot_valid;
  logic [mktr_pkg::DEV_W-1:0]      slot_device [SLOT_COUNT];

  // Latched item
  logic [2:0]                      item_cmd;
  logic [mktr_pkg::DEV_W-1:0]      item_dev;
  logic [mktr_pkg::KEY_W-1:0]      item_key;
  logic                            item_down;
  logic [mktr_pkg::TICK_W-1:0]     item_delta;
  logic                            item_rep;
  logic [SW-1:0]                   slot_reg;

  // Pending result
  logic [1:0] res_slot;
  logic       res_ok;
  logic       res_down;
  logic       res_edge;

  // Key memory
  mktr_pkg::key_entry_t key_mem [TOTAL];
  mktr_pkg::key_entry_t rdata;
  mktr_pkg::key_entry_t wr_data;
  logic [AW-1:0]        rd_addr;
  logic [AW-1:0]        wr_addr;
  logic                 wr_en;

  // Tick work registers
  mktr_pkg::key_entry_t            ent;
  logic signed [17:0]              cd_reg;
  logic [15:0]                     div_rem;
  logic [15:0]                     div_q;
  logic [mktr_pkg::DIV_CNT_W-1:0]  div_cnt;

  // Shared subtractor
  logic signed [17:0] sub_a;
  logic signed [17:0] sub_b;
  logic signed [17:0] sub_y;

  // Decode helpers
  logic                         acc;
  logic [mktr_pkg::KEY_W-1:0]   in_key;
  logic [1:0]                   in_qslot;
  logic                         in_key_ok;
  logic                         in_q_ok;
  logic                         key_ok;
  logic                         hit;
  logic                         free;
  logic [SW-1:0]                hit_idx;
  logic [SW-1:0]                free_idx;
  logic [SW-1:0]                map_slot;
  logic                         map_clear;
  logic                         map_create;
  logic [AW-1:0]                map_base;
  logic [AW-1:0]                key_addr;
  logic signed [17:0]           cd_sel;
  logic                         cd_pos;
  logic                         out_free;
  logic                         sweep_done;
  logic                         div_done;

  assign cfg_ready = 1'b1;
  assign iv        = (cfg_iv == 16'd0) ? 16'd1 : cfg_iv;

  assign acc       = s_tvalid && s_tready;
  assign in_key    = s_tdata[40:32];
  assign in_qslot  = s_tdata[59:58];
  assign in_key_ok = 32'(in_key) < 32'(KEY_COUNT);
  assign in_q_ok   = 32'(in_qslot) < 32'(SLOT_COUNT);
  assign key_ok    = 32'(item_key) < 32'(KEY_COUNT);

  assign key_addr   = AW'(slot_reg) * AW'(KEY_COUNT) + AW'(item_key);
  assign out_free   = !m_tvalid || m_tready;
  assign sweep_done = (sweep_addr == sweep_end);
  assign div_done   = (div_cnt == mktr_pkg::DIV_CNT_W'(mktr_pkg::DIV_STEPS - 1));
  assign sub_y      = sub_a - sub_b;

  // Find the device's slot and the lowest free slot
  always_comb begin
    hit      = 1'b0;
    free     = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
      if (slot_valid[s] && (slot_device[s] == item_dev)) begin
        hit     = 1'b1;
        hit_idx = SW'(s);
      end
      if (!slot_valid[s]) begin
        free     = 1'b1;
        free_idx = SW'(s);
      end
    end
  end

  // Mapping decisions for key event, add and remove
  always_comb begin
    map_slot   = hit ? hit_idx : free_idx;
    map_base   = AW'(map_slot) * AW'(KEY_COUNT);
    map_create = !hit && free &&
                 ((item_cmd == mktr_pkg::CMD_KEY) || (item_cmd == mktr_pkg::CMD_ADD));
    map_clear  = map_create || (hit && (item_cmd == mktr_pkg::CMD_REMOVE));
  end

  // Countdown after this tick, before any wrap
  always_comb begin
    cd_sel = rdata.level_last ? sub_y : $signed({2'b00, cfg_init});
    cd_pos = !cd_sel[17] && (cd_sel != 18'sd0);
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      mktr_pkg::ST_CLR:     if (sweep_done) state_next = clr_then;
      mktr_pkg::ST_IDLE: begin
        if (acc) begin
          case (s_tuser)
            mktr_pkg::CMD_KEY,
            mktr_pkg::CMD_ADD,
            mktr_pkg::CMD_REMOVE: state_next = mktr_pkg::ST_MAP;
            mktr_pkg::CMD_TICK:   state_next = mktr_pkg::ST_TK_RD;
            mktr_pkg::CMD_QUERY:
              state_next = (in_q_ok && in_key_ok) ? mktr_pkg::ST_Q_RD : mktr_pkg::ST_RESP;
            mktr_pkg::CMD_CLEAR:  state_next = mktr_pkg::ST_CLR;
            default:              state_next = mktr_pkg::ST_RESP;
          endcase
        end
      end
      mktr_pkg::ST_MAP: begin
        if (map_clear) begin
          state_next = mktr_pkg::ST_CLR;
        end else if (hit && (item_cmd == mktr_pkg::CMD_KEY) && key_ok) begin
          state_next = mktr_pkg::ST_KEY_RD;
        end else begin
          state_next = mktr_pkg::ST_RESP;
        end
      end
      mktr_pkg::ST_KEY_RD:  state_next = mktr_pkg::ST_KEY_WR;
      mktr_pkg::ST_KEY_WR:  state_next = mktr_pkg::ST_RESP;
      mktr_pkg::ST_Q_RD:    state_next = mktr_pkg::ST_Q_DATA;
      mktr_pkg::ST_Q_DATA:  state_next = mktr_pkg::ST_RESP;
      mktr_pkg::ST_TK_RD:   state_next = mktr_pkg::ST_TK_CALC;
      mktr_pkg::ST_TK_CALC: begin
        if (!rdata.level_now || cd_pos) begin
          state_next = mktr_pkg::ST_TK_WR;
        end else begin
          state_next = mktr_pkg::ST_TK_NEG;
        end
      end
      mktr_pkg::ST_TK_NEG:  state_next = mktr_pkg::ST_TK_DIV;
      mktr_pkg::ST_TK_DIV:  if (div_done) state_next = mktr_pkg::ST_TK_FIN;
      mktr_pkg::ST_TK_FIN:  state_next = mktr_pkg::ST_TK_WR;
      mktr_pkg::ST_TK_WR:
        state_next = sweep_done ? mktr_pkg::ST_RESP : mktr_pkg::ST_TK_RD;
      mktr_pkg::ST_RESP:    if (out_free) state_next = mktr_pkg::ST_IDLE;
      default:              state_next = mktr_pkg::ST_IDLE;
    endcase
  end

  // Memory controls, shared subtractor operands and handshake
  always_comb begin
    s_tready = 1'b0;
    rd_addr  = key_addr;
    wr_en    = 1'b0;
    wr_addr  = sweep_addr;
    wr_data  = '0;
    sub_a    = '0;
    sub_b    = '0;
    case (state)
      mktr_pkg::ST_IDLE:    s_tready = 1'b1;
      mktr_pkg::ST_CLR:     wr_en = 1'b1;
      mktr_pkg::ST_KEY_WR: begin
        wr_en             = 1'b1;
        wr_addr           = key_addr;
        wr_data           = rdata;
        wr_data.level_now = item_down;
      end
      mktr_pkg::ST_TK_RD:   rd_addr = sweep_addr;
      mktr_pkg::ST_TK_CALC: begin
        sub_a = {rdata.countdown[mktr_pkg::CD_W-1], rdata.countdown};
        sub_b = $signed({2'b00, item_delta});
      end
      mktr_pkg::ST_TK_NEG: begin
        sub_a = '0;
        sub_b = cd_reg;
      end
      mktr_pkg::ST_TK_DIV: begin
        sub_a = $signed({1'b0, div_rem, div_q[15]});
        sub_b = $signed({2'b00, iv});
      end
      mktr_pkg::ST_TK_FIN: begin
        sub_a = $signed({2'b00, iv});
        sub_b = $signed({2'b00, div_rem});
      end
      mktr_pkg::ST_TK_WR: begin
        wr_en   = 1'b1;
        wr_data = ent;
      end
      default: ;
    endcase
  end

  // Key memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_data;
    end
    rdata <= key_mem[rd_addr];
  end

  // Control state: sequencer, sweep range, slot valid bits, config, result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= mktr_pkg::ST_CLR;
      clr_then   <= mktr_pkg::ST_IDLE;
      sweep_addr <= '0;
      sweep_end  <= AW'(TOTAL - 1);
      slot_valid <= '0;
      cfg_init   <= mktr_pkg::RESET_INITIAL_DELAY;
      cfg_iv     <= mktr_pkg::RESET_REPEAT_INTERVAL;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;

      // Take register writes
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == mktr_pkg::CFG_INITIAL_DELAY) begin
          cfg_init <= cfg_data;
        end else if (cfg_index == mktr_pkg::CFG_REPEAT_INTERVAL) begin
          cfg_iv <= cfg_data;
        end
      end

      // Set up sweeps over all keys
      if (acc && ((s_tuser == mktr_pkg::CMD_TICK) || (s_tuser == mktr_pkg::CMD_CLEAR))) begin
        sweep_addr <= '0;
        sweep_end  <= AW'(TOTAL - 1);
        clr_then   <= mktr_pkg::ST_RESP;
      end

      // Claim or free a slot and set up clearing of its keys
      if (state == mktr_pkg::ST_MAP) begin
        if (map_create) begin
          slot_valid[free_idx] <= 1'b1;
        end else if (hit && (item_cmd == mktr_pkg::CMD_REMOVE)) begin
          slot_valid[hit_idx] <= 1'b0;
        end
        if (map_clear) begin
          sweep_addr <= map_base;
          sweep_end  <= map_base + AW'(KEY_COUNT - 1);
          clr_then   <= ((item_cmd == mktr_pkg::CMD_KEY) && key_ok) ?
                        mktr_pkg::ST_KEY_RD : mktr_pkg::ST_RESP;
        end
      end

      // Advance the sweep
      if ((state == mktr_pkg::ST_CLR) || (state == mktr_pkg::ST_TK_WR)) begin
        sweep_addr <= sweep_addr + AW'(1);
      end

      // Hold the result until taken
      if ((state == mktr_pkg::ST_RESP) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload: latched item, slot ids, result fields, tick work registers
  always_ff @(posedge clk) begin
    if (acc) begin
      item_cmd   <= s_tuser;
      item_dev   <= s_tdata[31:0];
      item_key   <= in_key;
      item_down  <= s_tdata[41];
      item_delta <= s_tdata[57:42];
      item_rep   <= s_tdata[60];
      slot_reg   <= SW'(in_qslot);
      res_down   <= 1'b0;
      res_edge   <= 1'b0;
      if (s_tuser == mktr_pkg::CMD_QUERY) begin
        res_slot <= in_qslot;
        res_ok   <= in_q_ok;
      end else begin
        res_slot <= '0;
        res_ok   <= 1'b0;
      end
    end

    if ((state == mktr_pkg::ST_MAP) && (hit || map_create)) begin
      slot_reg <= map_slot;
      res_slot <= 2'(map_slot);
      res_ok   <= 1'b1;
      if (map_create) begin
        slot_device[free_idx] <= item_dev;
      end
    end

    if (state == mktr_pkg::ST_Q_DATA) begin
      res_down <= rdata.level_now;
      res_edge <= item_rep ? rdata.rep_flag : rdata.press;
    end

    // Build the new entry of a swept key
    if (state == mktr_pkg::ST_TK_CALC) begin
      cd_reg <= cd_sel;
      if (rdata.level_now) begin
        ent.level_now  <= 1'b1;
        ent.level_last <= 1'b1;
        ent.press      <= !rdata.level_last;
        ent.rep_flag   <= !rdata.level_last || !cd_pos;
        ent.countdown  <= cd_sel[mktr_pkg::CD_W-1:0];
      end else begin
        ent <= '0;
      end
    end

    // Remainder of the overshoot by the interval, one bit a step
    if (state == mktr_pkg::ST_TK_NEG) begin
      div_q   <= sub_y[15:0];
      div_rem <= '0;
      div_cnt <= '0;
    end
    if (state == mktr_pkg::ST_TK_DIV) begin
      div_q   <= {div_q[14:0], 1'b0};
      div_cnt <= div_cnt + mktr_pkg::DIV_CNT_W'(1);
      if (!sub_y[17]) begin
        div_rem <= sub_y[15:0];
      end else begin
        div_rem <= {div_rem[14:0], div_q[15]};
      end
    end
    if (state == mktr_pkg::ST_TK_FIN) begin
      ent.countdown <= sub_y[mktr_pkg::CD_W-1:0];
    end

    if ((state == mktr_pkg::ST_RESP) && out_free) begin
      m_tdata <= {4'b0000, res_edge, res_down, res_slot};
      m_tuser <= res_ok;
    end
  end

  // The remainder stays below the interval during the divide
  assert property (@(posedge clk) disable iff (rst)
    (state == mktr_pkg::ST_TK_DIV) |-> (div_rem < iv))
    else $error("remainder not below repeat interval");

  // A held key always leaves the tick with a positive countdown
  assert property (@(posedge clk) disable iff (rst)
    ((state == mktr_pkg::ST_TK_WR) && ent.level_now) |-> (ent.countdown > 0))
    else $error("held key written with non-positive countdown");

  // Key memory writes stay inside the key array
  assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (32'(wr_addr) < 32'(TOTAL)))
    else $error("key memory write out of range");

  // A finished item reaches the result register in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    ((state == mktr_pkg::ST_RESP) && out_free) |=> (m_tvalid && (state == mktr_pkg::ST_IDLE)))
    else $error("result not presented");

endmodule
